// ----- rtl/core/matrix_multiply_engine_macros.svh -----
// ----------------------------------------------------------------------------
// Matrix multiply engine assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define MME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix multiply engine: check failed");

// next-cycle implication, skipped while reset is high
`define MME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix multiply engine: check failed");

// next-cycle implication that also covers the reset cycles
`define MME_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("matrix multiply engine: reset check failed");

`endif

// ----- rtl/core/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Sizes, opcodes, sequencer states and the beat types passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  localparam int DIM        = 8;
  localparam int IDX_W      = 3;
  localparam int KW         = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = 35;
  localparam int LEFT_DEPTH = 1 << (2 * KW);

  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_DRAIN
  } state_t;

  // one left operand travelling down the chain of cells
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              lastk;
    logic [KW-1:0]     k;
    logic [DATA_W-1:0] a;
  } token_t;

  // right operand write, broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [KW-1:0]     row;
    logic [KW-1:0]     col;
    logic [DATA_W-1:0] data;
  } bwr_t;

endpackage

`default_nettype wire

// ----- rtl/core/mme_cell.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of the right matrix and one accumulator. Multiplies each
// passing left operand with its local element, sums over k, and forwards the
// operand to the next cell. Accumulators shift toward the head to drain.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_cell
  import mme_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire token_t                  t_in,
  output token_t                       t_out,
  input  wire logic                    b_we,
  input  wire logic [KW-1:0]           b_addr,
  input  wire logic [DATA_W-1:0]       b_data,
  input  wire logic                    shift,
  input  wire logic signed [SUM_W-1:0] acc_in,
  output logic signed [SUM_W-1:0]      acc,
  output logic                         done
);

  logic [DATA_W-1:0]        b_mem [DIM];
  logic signed [DATA_W-1:0] a_val;
  logic signed [DATA_W-1:0] b_val;
  logic signed [PROD_W-1:0] prod;
  logic                     p_valid;
  logic                     p_first;
  logic                     p_last;
  token_t                   tok;

  assign a_val = $signed(t_in.a);
  assign b_val = $signed(b_mem[t_in.k]);
  assign t_out = tok;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_addr] <= b_data;
    end
  end

  // forward the operand one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= t_in.valid;
    end
    tok.first <= t_in.first;
    tok.lastk <= t_in.lastk;
    tok.k     <= t_in.k;
    tok.a     <= t_in.a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= t_in.valid;
    end
    p_first <= t_in.first;
    p_last  <= t_in.lastk;
    prod    <= a_val * b_val;
  end

  // restart on the first k, otherwise add; drain shifts the chain toward the head
  always_ff @(posedge clk) begin
    if (p_valid) begin
      if (p_first) begin
        acc <= SUM_W'(prod);
      end else begin
        acc <= acc + SUM_W'(prod);
      end
    end else if (shift) begin
      acc <= acc_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_valid && p_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mme_seq.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply sequencer
// Takes input beats, holds the left matrix, feeds one row of it into the
// chain per pass, waits for the chain, then drains the row through the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mme_seq
  import mme_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              opcode,
  input  wire logic [IDX_W-1:0]        row,
  input  wire logic [IDX_W-1:0]        col,
  input  wire logic [DATA_W-1:0]       value,
  output token_t                       tok,
  output bwr_t                         bwr,
  output logic                         shift,
  input  wire logic signed [SUM_W-1:0] acc_head,
  input  wire logic                    done_tail,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic signed [SUM_W-1:0]      dot_sum,
  output logic                         last
);

  logic [DATA_W-1:0] left_mem [LEFT_DEPTH];

  state_t        state;
  state_t        state_next;
  logic [KW-1:0] i_cnt;
  logic [KW-1:0] k_cnt;
  logic [KW-1:0] j_cnt;
  logic          i_last;
  logic          k_last;
  logic          j_last;
  logic          in_fire;
  logic          in_range;
  logic          lwr_en;
  logic          compute_go;
  logic          issue;
  logic          drain_load;

  assign in_fire    = in_valid && in_ready;
  assign in_range   = ({1'b0, row} < (IDX_W + 1)'(DIM)) && ({1'b0, col} < (IDX_W + 1)'(DIM));
  assign lwr_en     = in_fire && (opcode == OP_LOAD_LEFT) && in_range;
  assign compute_go = in_fire && (opcode == OP_COMPUTE);

  assign bwr.en   = in_fire && (opcode == OP_LOAD_RIGHT) && in_range;
  assign bwr.row  = row[KW-1:0];
  assign bwr.col  = col[KW-1:0];
  assign bwr.data = value;

  assign i_last = (i_cnt == KW'(DIM - 1));
  assign k_last = (k_cnt == KW'(DIM - 1));
  assign j_last = (j_cnt == KW'(DIM - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (compute_go) state_next = S_ISSUE;
      end
      S_ISSUE: begin
        if (k_last) state_next = S_WAIT;
      end
      S_WAIT: begin
        if (done_tail) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_load && j_last) state_next = i_last ? S_IDLE : S_ISSUE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    issue      = 1'b0;
    drain_load = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_ISSUE: issue = 1'b1;
      S_WAIT:  ;
      S_DRAIN: drain_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign shift = drain_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt <= '0;
      k_cnt <= '0;
      j_cnt <= '0;
    end else begin
      if (issue) begin
        k_cnt <= k_last ? '0 : k_cnt + 1'b1;
      end
      if (drain_load) begin
        j_cnt <= j_last ? '0 : j_cnt + 1'b1;
        if (j_last) begin
          i_cnt <= i_last ? '0 : i_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      left_mem[{row[KW-1:0], col[KW-1:0]}] <= value;
    end
  end

  // operand beat lines up with the registered memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= issue;
    end
    tok.first <= (k_cnt == '0);
    tok.lastk <= k_last;
    tok.k     <= k_cnt;
    tok.a     <= left_mem[{i_cnt, k_cnt}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_load) begin
      out_row <= IDX_W'(i_cnt);
      out_col <= IDX_W'(j_cnt);
      dot_sum <= acc_head;
      last    <= i_last && j_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/matrix_multiply_engine.sv -----
// Load beats are accepted while the engine is idle; the next beat may follow at once.
// A compute beat runs row by row: the sequencer issues the row into the chain of
// cells, waits for the last cell to finish it, then drains DIM output beats,
// each waiting while the output is stalled. Input is held off during a compute.
// Reset clears the control state only; operand stores hold garbage until written.
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Square signed Q8.8 matrix product on a chain of multiply-accumulate cells.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_engine
  import mme_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              opcode,
  input  wire logic [IDX_W-1:0]        row,
  input  wire logic [IDX_W-1:0]        col,
  input  wire logic signed [DATA_W-1:0] value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic signed [SUM_W-1:0]      dot_sum,
  output logic                         last
);

  token_t                   tok_head;
  token_t                   tok_nx  [DIM];
  token_t                   tok_in  [DIM];
  logic signed [SUM_W-1:0]  acc_v   [DIM];
  logic signed [SUM_W-1:0]  acc_in  [DIM];
  logic [DIM-1:0]           done_v;
  logic [DIM-1:0]           b_we;
  bwr_t                     bwr;
  logic                     shift;

  mme_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .value     (value),
    .tok       (tok_head),
    .bwr       (bwr),
    .shift     (shift),
    .acc_head  (acc_v[0]),
    .done_tail (done_v[DIM-1]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .dot_sum   (dot_sum),
    .last      (last)
  );

  for (genvar j = 0; j < DIM; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign tok_in[j] = tok_head;
    end else begin : g_body
      assign tok_in[j] = tok_nx[j-1];
    end

    if (j == DIM - 1) begin : g_tail
      assign acc_in[j] = '0;
    end else begin : g_link
      assign acc_in[j] = acc_v[j+1];
    end

    assign b_we[j] = bwr.en && (bwr.col == KW'(j));

    mme_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .t_in   (tok_in[j]),
      .t_out  (tok_nx[j]),
      .b_we   (b_we[j]),
      .b_addr (bwr.row),
      .b_data (bwr.data),
      .shift  (shift),
      .acc_in (acc_in[j]),
      .acc    (acc_v[j]),
      .done   (done_v[j])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/core/mme_checker.sv -----
// ----------------------------------------------------------------------------
// Matrix multiply engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_multiply_engine_macros.svh"

module mme_checker
  import mme_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [IDX_W-1:0]        out_row,
  input wire logic [IDX_W-1:0]        out_col,
  input wire logic signed [SUM_W-1:0] dot_sum,
  input wire logic                    last
);

  // a stalled result beat stays valid and holds its sum and column
  `MME_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dot_sum) && $stable(out_col))

  // last marks the bottom-right element only
  `MME_ASSERT_NOW(a_last_pos, out_valid && last, (out_row == IDX_W'(DIM - 1)) && (out_col == IDX_W'(DIM - 1)))

  // no new beat is taken while a product matrix is still coming out
  `MME_ASSERT_NOW(a_busy_block, out_valid && !last, !in_ready)

  // a row advances one column per taken beat
  `MME_ASSERT_NEXT(a_col_step, out_valid && out_ready && (out_col != IDX_W'(DIM - 1)), out_valid && (out_col == $past(out_col) + 1'b1))

  // reset empties the output
  `MME_ASSERT_RESET(a_reset_empty, rst, !out_valid)

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire

// ----- verif/matrix_multiply_engine_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Loads signed Q8.8 operands into both stores, runs products and checks every
// emitted element, in row-major order, against a local model of the stores.
// A directed table covers full-scale and mixed matrices and ignored beats.
// A random phase follows with row and column refills, stalls on both sides
// and one long output hold-off.
// ----------------------------------------------------------------------------

module matrix_multiply_engine_test;
  import mme_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 70;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 2 * DIM + 40;

  typedef struct {
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic signed [SUM_W-1:0] sum;
    logic                    fin;
  } product_t;

  typedef enum logic { ROW_BEAT, ROW_FILL } row_kind_t;

  // a fill row loads the whole store named by op with one value
  typedef struct {
    row_kind_t               kind;
    logic [1:0]              op;
    logic [IDX_W-1:0]        r;
    logic [IDX_W-1:0]        c;
    logic [DATA_W-1:0]       v;
    bit                      typed;
    logic signed [SUM_W-1:0] sum;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               opcode;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic signed [SUM_W-1:0]  dot_sum;
  logic                     last;

  logic signed [DATA_W-1:0] left_mat  [DIM*DIM];
  logic signed [DATA_W-1:0] right_mat [DIM*DIM];
  product_t                 product_queue [$];
  plan_row_t                plan [15];

  bit calm;
  bit hold_req;
  int hold_left;
  int fail_count;
  int loads_sent;
  int computes_sent;
  int ignored_sent;
  int products_checked;

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .dot_sum   (dot_sum),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [DATA_W-1:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      // small magnitudes around zero
      2: return 16'($urandom_range(0, 512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // queue the full product matrix, row-major, from the current operand copies
  task automatic queue_products(input bit typed, input logic signed [SUM_W-1:0] typed_sum);
    product_t p;
    longint   acc;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++)
          acc += longint'(left_mat[i*DIM+k]) * longint'(right_mat[k*DIM+j]);
        p.r   = IDX_W'(i);
        p.c   = IDX_W'(j);
        p.sum = typed ? typed_sum : acc[SUM_W-1:0];
        p.fin = (i == DIM - 1) && (j == DIM - 1);
        product_queue.push_back(p);
      end
    end
  endtask

  task automatic send_beat(input logic [1:0] op, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v,
                           input bit typed, input logic signed [SUM_W-1:0] typed_sum);
    if (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    row      <= r;
    col      <= c;
    value    <= v;
    case (op)
      OP_LOAD_LEFT, OP_LOAD_RIGHT: begin
        if (r < DIM && c < DIM) begin
          if (op == OP_LOAD_LEFT)
            left_mat[r*DIM+c] = v;
          else
            right_mat[r*DIM+c] = v;
          loads_sent++;
        end else begin
          ignored_sent++;
        end
      end
      OP_COMPUTE: begin
        queue_products(typed, typed_sum);
        computes_sent++;
      end
      default: ignored_sent++;
    endcase
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (product_queue.size() != 0);
  endtask

  // output side: check each beat, then pick the next ready
  initial begin
    product_t exp;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (product_queue.size() == 0) begin
          $error("unexpected product beat at row %0d col %0d", out_row, out_col);
          fail_count++;
        end else begin
          exp = product_queue.pop_front();
          products_checked++;
          if (out_row !== exp.r) begin
            $error("out_row: expected %0d, got %0d", exp.r, out_row);
            fail_count++;
          end
          if (out_col !== exp.c) begin
            $error("out_col: expected %0d, got %0d", exp.c, out_col);
            fail_count++;
          end
          if (dot_sum !== exp.sum) begin
            $error("dot_sum: expected %0d, got %0d", exp.sum, dot_sum);
            fail_count++;
          end
          if (last !== exp.fin) begin
            $error("last: expected %0b, got %0b", exp.fin, last);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin
    int         counted;
    int         draw;
    int         n;
    logic [1:0] op;
    bit         hold_done;
    bit         drain_done;

    rst      = 1'b1;
    in_valid = 1'b0;
    opcode   = OP_LOAD_LEFT;
    row      = '0;
    col      = '0;
    value    = '0;
    calm     = 1'b0;
    hold_req = 1'b0;

    plan = '{
      '{ROW_FILL, OP_LOAD_LEFT,  3'd0, 3'd0, 16'h8000, 1'b0, '0},
      '{ROW_FILL, OP_LOAD_RIGHT, 3'd0, 3'd0, 16'h8000, 1'b0, '0},
      '{ROW_BEAT, OP_COMPUTE,    3'd7, 3'd7, 16'h7fff, 1'b1, 35'sd8589934592},
      '{ROW_FILL, OP_LOAD_RIGHT, 3'd0, 3'd0, 16'h7fff, 1'b0, '0},
      '{ROW_BEAT, OP_COMPUTE,    3'd3, 3'd5, 16'hffff, 1'b1, -35'sd8589672448},
      '{ROW_BEAT, OP_UNUSED,     3'd7, 3'd7, 16'h8000, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_LEFT,  3'd0, 3'd0, 16'hffff, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_LEFT,  3'd7, 3'd7, 16'h0001, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_RIGHT, 3'd0, 3'd7, 16'h8000, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_RIGHT, 3'd7, 3'd0, 16'h0000, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_RIGHT, 3'd3, 3'd4, 16'h5a5a, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_LEFT,  3'd4, 3'd3, 16'ha5a5, 1'b0, '0},
      '{ROW_BEAT, OP_COMPUTE,    3'd5, 3'd2, 16'h1234, 1'b0, '0},
      '{ROW_BEAT, OP_LOAD_RIGHT, 3'd6, 3'd1, 16'hffff, 1'b0, '0},
      '{ROW_BEAT, OP_COMPUTE,    3'd2, 3'd6, 16'h00ff, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[p]) begin
      if (plan[p].kind == ROW_FILL) begin
        for (int r = 0; r < DIM; r++)
          for (int c = 0; c < DIM; c++)
            send_beat(plan[p].op, IDX_W'(r), IDX_W'(c), plan[p].v, 1'b0, '0);
      end else begin
        send_beat(plan[p].op, plan[p].r, plan[p].c, plan[p].v, plan[p].typed, plan[p].sum);
      end
    end
    wait_drained();

    counted    = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (counted < RANDOM_BEATS) begin
      calm = (counted >= 20) && (counted < 45);
      if (counted >= 50 && !hold_done) begin
        // stall the output while later loads wait behind this product
        hold_done = 1'b1;
        hold_req  = 1'b1;
        send_beat(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                  rand_q88(), 1'b0, '0);
        counted++;
      end else if (counted >= 60 && !drain_done) begin
        drain_done = 1'b1;
        wait_drained();
      end else begin
        draw = $urandom_range(0, 99);
        if (draw < 4) begin
          send_beat(OP_UNUSED, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                    rand_q88(), 1'b0, '0);
        end else if (draw < 9) begin
          send_beat(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                    rand_q88(), 1'b0, '0);
          counted++;
        end else if (draw < 15) begin
          // refill one row of the left matrix or one column of the right one
          op = 2'($urandom_range(0, 1));
          n  = $urandom_range(0, DIM - 1);
          for (int k = 0; k < DIM; k++)
            send_beat(op, IDX_W'((op == OP_LOAD_LEFT) ? n : k),
                      IDX_W'((op == OP_LOAD_LEFT) ? k : n), rand_q88(), 1'b0, '0);
          counted += DIM;
        end else begin
          send_beat(2'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 7)),
                    IDX_W'($urandom_range(0, 7)), rand_q88(), 1'b0, '0);
          counted++;
        end
      end
    end
    calm = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d element loads, %0d products and %0d ignored beats", loads_sent,
             computes_sent, ignored_sent);
    $display("compared %0d product elements with %0d mismatches", products_checked,
             fail_count);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
